[rtl/itp_pkg.sv]
package itp_pkg;

	// token id width shared by the payload structs
	localparam int TOKEN_ID_BITS = 16;
	localparam int STACK_DEPTH   = 32;

	typedef enum logic [2:0] {
		KIND_CONST  = 3'd0,
		KIND_FUNC   = 3'd1,
		KIND_SEP    = 3'd2,
		KIND_OP     = 3'd3,
		KIND_LPAREN = 3'd4,
		KIND_RPAREN = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_TOKEN    = 3'd0,
		ST_MISMATCH = 3'd1,
		ST_UNDEF    = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_END_OK   = 3'd4,
		ST_END_ERR  = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0]               kind;
		logic [TOKEN_ID_BITS-1:0] token_id;
		logic [3:0]               precedence;
		logic                     assoc_left;
		logic                     last_token;
	} token_t;

	typedef struct packed {
		logic [2:0]               out_kind;
		logic [TOKEN_ID_BITS-1:0] out_token_id;
		logic [2:0]               status;
		logic                     last_of_run;
	} result_t;

	// one operator stack entry
	typedef struct packed {
		logic [2:0]               kind;
		logic [TOKEN_ID_BITS-1:0] token_id;
		logic [3:0]               prec;
		logic                     assoc;
	} entry_t;

	typedef enum logic [1:0] {
		MODE_SEP,
		MODE_OP,
		MODE_RPAREN,
		MODE_FLUSH
	} mode_t;

	typedef enum logic [2:0] {
		ACT_POP_GO,
		ACT_POP_STOP,
		ACT_STOP,
		ACT_DROP,
		ACT_MISMATCH
	} act_t;

	typedef struct packed {
		mode_t      mode;
		logic [3:0] prec;
		logic       assoc;
	} cmp_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_READ,
		S_EVAL,
		S_PUSH,
		S_ERR,
		S_LAST,
		S_END,
		S_FIN
	} state_t;

endpackage

[rtl/itp_ram.sv]
module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/itp_cmp.sv]
module itp_cmp (
	input  itp_pkg::cmp_req_t req,
	input  itp_pkg::entry_t   top,
	output itp_pkg::act_t     act
);

	logic is_lparen;
	logic is_func;
	logic binds;

	assign is_lparen = (top.kind == itp_pkg::KIND_LPAREN);
	assign is_func   = (top.kind == itp_pkg::KIND_FUNC);
	// stacked operator binds at least as tight (strictly for right assoc)
	assign binds     = req.assoc ? (req.prec <= top.prec) : (req.prec < top.prec);

	always_comb begin
		act = itp_pkg::ACT_STOP;
		unique case (req.mode)
			itp_pkg::MODE_SEP: begin
				act = is_lparen ? itp_pkg::ACT_STOP : itp_pkg::ACT_POP_GO;
			end
			itp_pkg::MODE_RPAREN: begin
				act = is_lparen ? itp_pkg::ACT_DROP : itp_pkg::ACT_POP_GO;
			end
			itp_pkg::MODE_FLUSH: begin
				act = is_lparen ? itp_pkg::ACT_MISMATCH : itp_pkg::ACT_POP_GO;
			end
			itp_pkg::MODE_OP: begin
				priority if (is_lparen) begin
					act = itp_pkg::ACT_STOP;
				end else if (is_func) begin
					act = itp_pkg::ACT_POP_STOP;
				end else if (binds) begin
					act = itp_pkg::ACT_POP_GO;
				end else begin
					act = itp_pkg::ACT_STOP;
				end
			end
		endcase
	end

endmodule

[rtl/infix_to_postfix_converter.sv]
// channel | direction | handshake            | payload
// tok     | in        | tok_valid, tok_stall | itp_pkg::token_t  (one infix token)
// res     | out       | res_valid, res_stall | itp_pkg::result_t (postfix token or status)
//
// one token at a time; each popped entry takes a ram read (S_READ) then a compare (S_EVAL),
// and errors (S_ERR) and end of expression (S_END) each add a state of their own
// the single read port of the stack ram and the shared compare unit set the pop rate
// reset clears the sequencer, stack count, discard flag and output valid; ram is not cleared
// results go through a pending slot and an output register, so a stall on res holds the
// sequencer only when it has a new result to place; tok_stall is high outside idle
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	output logic              tok_stall,
	input  itp_pkg::token_t   tok,
	output logic              res_valid,
	input  logic              res_stall,
	output itp_pkg::result_t  res
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int EW = $bits(itp_pkg::entry_t);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	// sequencer state
	itp_pkg::state_t  state_q, state_d;
	itp_pkg::token_t  tok_q;
	logic             flush_q, flush_d;
	itp_pkg::status_t err_q, err_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic             discard_q, discard_d;

	// result path: pending slot holds the newest result until we know if it is the last
	logic             pend_valid_q;
	itp_pkg::result_t pend_q;
	logic             out_valid_q;
	itp_pkg::result_t out_q;
	itp_pkg::result_t out_d;

	logic             out_free;
	logic             emit;
	logic             fin;
	logic             load_out;
	logic             tok_load;
	itp_pkg::result_t emit_res;

	// stack ram and compare unit
	logic              ram_we;
	logic              ram_re;
	logic [EW-1:0]     rd_data;
	itp_pkg::entry_t   top_entry;
	itp_pkg::entry_t   push_entry;
	logic [CW-1:0]     cnt_dec;
	itp_pkg::cmp_req_t req;
	itp_pkg::act_t     act;
	itp_pkg::state_t   empty_to;
	logic              is_op;

	assign out_free  = !out_valid_q || !res_stall;
	assign cnt_dec   = cnt_q - CW'(1);
	assign top_entry = itp_pkg::entry_t'(rd_data);
	assign is_op     = (tok_q.kind == itp_pkg::KIND_OP);

	// what the current token does with the stack
	always_comb begin
		req.prec  = tok_q.precedence;
		req.assoc = tok_q.assoc_left;
		priority if (flush_q) begin
			req.mode = itp_pkg::MODE_FLUSH;
		end else if (tok_q.kind == itp_pkg::KIND_SEP) begin
			req.mode = itp_pkg::MODE_SEP;
		end else if (tok_q.kind == itp_pkg::KIND_RPAREN) begin
			req.mode = itp_pkg::MODE_RPAREN;
		end else begin
			req.mode = itp_pkg::MODE_OP;
		end
	end

	// where to go once the stack runs empty while popping
	always_comb begin
		unique case (req.mode)
			itp_pkg::MODE_OP:    empty_to = itp_pkg::S_PUSH;
			itp_pkg::MODE_FLUSH: empty_to = itp_pkg::S_END;
			default:             empty_to = itp_pkg::S_ERR;
		endcase
	end

	// operator fields only kept for operators
	assign push_entry.kind     = tok_q.kind;
	assign push_entry.token_id = tok_q.token_id;
	assign push_entry.prec     = is_op ? tok_q.precedence : 4'd0;
	assign push_entry.assoc    = is_op ? tok_q.assoc_left : 1'b0;

	itp_ram #(
		.WIDTH(EW),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(push_entry),
		.re   (ram_re),
		.raddr(cnt_dec[AW-1:0]),
		.rdata(rd_data)
	);

	itp_cmp u_cmp (
		.req(req),
		.top(top_entry),
		.act(act)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= itp_pkg::S_IDLE;
			flush_q   <= 1'b0;
			err_q     <= itp_pkg::ST_TOKEN;
			cnt_q     <= '0;
			discard_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			flush_q   <= flush_d;
			err_q     <= err_d;
			cnt_q     <= cnt_d;
			discard_q <= discard_d;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_load) begin
			tok_q <= tok;
		end
	end

	always_comb begin
		state_d   = state_q;
		flush_d   = flush_q;
		err_d     = err_q;
		cnt_d     = cnt_q;
		discard_d = discard_q;
		emit      = 1'b0;
		emit_res  = '0;
		fin       = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		tok_stall = 1'b1;
		tok_load  = 1'b0;
		unique case (state_q)
			itp_pkg::S_IDLE: begin
				tok_stall = 1'b0;
				if (tok_valid) begin
					tok_load = 1'b1;
					flush_d  = 1'b0;
					state_d  = itp_pkg::S_DISPATCH;
				end
			end
			itp_pkg::S_DISPATCH: begin
				if (discard_q) begin
					// swallowed until the last token of the expression
					state_d = itp_pkg::S_LAST;
				end else begin
					unique case (tok_q.kind)
						itp_pkg::KIND_CONST: begin
							if (out_free) begin
								emit                  = 1'b1;
								emit_res.out_kind     = itp_pkg::KIND_CONST;
								emit_res.out_token_id = tok_q.token_id;
								emit_res.status       = itp_pkg::ST_TOKEN;
								state_d               = itp_pkg::S_LAST;
							end
						end
						itp_pkg::KIND_FUNC, itp_pkg::KIND_LPAREN: begin
							state_d = itp_pkg::S_PUSH;
						end
						itp_pkg::KIND_SEP, itp_pkg::KIND_OP, itp_pkg::KIND_RPAREN: begin
							if (cnt_q == '0) begin
								err_d   = itp_pkg::ST_MISMATCH;
								state_d = empty_to;
							end else begin
								state_d = itp_pkg::S_READ;
							end
						end
						default: begin
							err_d   = itp_pkg::ST_UNDEF;
							state_d = itp_pkg::S_ERR;
						end
					endcase
				end
			end
			itp_pkg::S_READ: begin
				// fetch top of stack
				ram_re  = 1'b1;
				state_d = itp_pkg::S_EVAL;
			end
			itp_pkg::S_EVAL: begin
				unique case (act)
					itp_pkg::ACT_POP_GO, itp_pkg::ACT_POP_STOP: begin
						if (out_free) begin
							emit                  = 1'b1;
							emit_res.out_kind     = top_entry.kind;
							emit_res.out_token_id = top_entry.token_id;
							emit_res.status       = itp_pkg::ST_TOKEN;
							cnt_d                 = cnt_dec;
							priority if (act == itp_pkg::ACT_POP_STOP) begin
								state_d = itp_pkg::S_PUSH;
							end else if (cnt_dec == '0) begin
								err_d   = itp_pkg::ST_MISMATCH;
								state_d = empty_to;
							end else begin
								state_d = itp_pkg::S_READ;
							end
						end
					end
					itp_pkg::ACT_STOP: begin
						state_d = (req.mode == itp_pkg::MODE_OP) ? itp_pkg::S_PUSH
							: itp_pkg::S_LAST;
					end
					itp_pkg::ACT_DROP: begin
						// right paren drops its matching left paren
						cnt_d   = cnt_dec;
						state_d = itp_pkg::S_LAST;
					end
					itp_pkg::ACT_MISMATCH: begin
						err_d   = itp_pkg::ST_MISMATCH;
						state_d = itp_pkg::S_ERR;
					end
				endcase
			end
			itp_pkg::S_PUSH: begin
				if (cnt_q == FULL) begin
					err_d   = itp_pkg::ST_OVERFLOW;
					state_d = itp_pkg::S_ERR;
				end else begin
					ram_we  = 1'b1;
					cnt_d   = cnt_q + CW'(1);
					state_d = itp_pkg::S_LAST;
				end
			end
			itp_pkg::S_ERR: begin
				if (out_free) begin
					emit            = 1'b1;
					emit_res.status = err_q;
					discard_d       = 1'b1;
					cnt_d           = '0;
					state_d         = itp_pkg::S_LAST;
				end
			end
			itp_pkg::S_LAST: begin
				priority if (!tok_q.last_token) begin
					state_d = itp_pkg::S_FIN;
				end else if (discard_q || cnt_q == '0) begin
					state_d = itp_pkg::S_END;
				end else begin
					// flush the remaining stack
					flush_d = 1'b1;
					state_d = itp_pkg::S_READ;
				end
			end
			itp_pkg::S_END: begin
				if (out_free) begin
					emit            = 1'b1;
					emit_res.status = discard_q ? itp_pkg::ST_END_ERR : itp_pkg::ST_END_OK;
					discard_d       = 1'b0;
					cnt_d           = '0;
					state_d         = itp_pkg::S_FIN;
				end
			end
			itp_pkg::S_FIN: begin
				// release the held result, marked as the last of this token
				if (!pend_valid_q) begin
					state_d = itp_pkg::S_IDLE;
				end else if (out_free) begin
					fin     = 1'b1;
					state_d = itp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = itp_pkg::S_IDLE;
			end
		endcase
	end

	// a new result pushes the held one out; the end of a token flushes it
	assign load_out = (emit && pend_valid_q) || fin;

	// held result with its end-of-token mark
	always_comb begin
		out_d             = pend_q;
		out_d.last_of_run = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				pend_valid_q <= 1'b1;
			end else if (fin) begin
				pend_valid_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= load_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pend_q <= emit_res;
		end
		if (out_free && load_out) begin
			out_q <= out_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	// stack count stays within the ram
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("stack count above depth");

	// only a non-empty stack is ever compared
	a_eval_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == itp_pkg::S_EVAL |-> cnt_q != '0)
		else $error("compare on empty stack");

	// every token leaves nothing held back
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == itp_pkg::S_IDLE |-> !pend_valid_q)
		else $error("result held in idle");

	// discarding always goes with a cleared stack
	a_discard_empty: assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> cnt_q == '0)
		else $error("discard with stacked entries");

	// an error result puts the block into discard mode
	a_err_discard: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itp_pkg::S_ERR && out_free) |=> discard_q)
		else $error("error without discard");

endmodule

[sim/tb.sv]
module tb;
	import itp_pkg::*;

	// kind codes the package leaves without a name
	localparam logic [2:0] KIND_UNDEF_LO = 3'd6;
	localparam logic [2:0] KIND_UNDEF_HI = 3'd7;

	localparam int ITEM_COUNT   = 280;   // input tokens over the whole run
	localparam int IDLE_LIMIT   = 4000;  // cycles with no transfer on either side
	localparam int DRAIN_CYCLES = 60;    // quiet time after the last expected result
	localparam int ERR_SHOWN    = 10;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    tok_valid = 1'b0;
	logic    tok_stall;
	token_t  tok       = '0;
	logic    res_valid;
	logic    res_stall = 1'b0;
	result_t res;

	infix_to_postfix_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// shunting-yard predictor: private copy of the operator stack
	// ------------------------------------------------------------------
	entry_t  held_ops [STACK_DEPTH];
	int      held_cnt   = 0;
	bit      discarding = 1'b0;
	result_t step_q [$];     // results caused by the token just taken
	result_t postfix_q [$];  // postfix tokens and status words still to arrive

	function automatic void put(logic [2:0] k, logic [TOKEN_ID_BITS-1:0] id, status_t s);
		result_t r;
		r = '0;
		r.out_kind     = k;
		r.out_token_id = id;
		r.status       = s;
		step_q = {step_q, r};
	endfunction

	function automatic void pop_put();
		held_cnt--;
		put(held_ops[held_cnt].kind, held_ops[held_cnt].token_id, ST_TOKEN);
	endfunction

	// a push onto a full stack is an overflow and the entry is dropped
	function automatic status_t push_entry(entry_t e);
		if (held_cnt >= STACK_DEPTH)
			return ST_OVERFLOW;
		held_ops[held_cnt] = e;
		held_cnt++;
		return ST_TOKEN;
	endfunction

	function automatic void shunt_token(token_t t);
		status_t err;
		entry_t  e;
		bit      halt;
		err = ST_TOKEN;
		step_q.delete();
		if (!discarding) begin
			case (t.kind)
				KIND_CONST: put(KIND_CONST, t.token_id, ST_TOKEN);
				KIND_FUNC, KIND_LPAREN: begin
					e = '0;
					e.kind     = t.kind;
					e.token_id = t.token_id;
					err = push_entry(e);
				end
				KIND_SEP: begin
					while (held_cnt > 0 && held_ops[held_cnt-1].kind != KIND_LPAREN)
						pop_put();
					if (held_cnt == 0)
						err = ST_MISMATCH;
				end
				KIND_OP: begin
					halt = 1'b0;
					while (held_cnt > 0 && !halt) begin
						e = held_ops[held_cnt-1];
						if (e.kind == KIND_LPAREN)
							halt = 1'b1;
						else if (e.kind == KIND_FUNC) begin
							// one function is taken off, then the scan ends
							pop_put();
							halt = 1'b1;
						end else if (t.assoc_left ? (t.precedence <= e.prec)
								: (t.precedence < e.prec))
							pop_put();
						else
							halt = 1'b1;
					end
					e = '0;
					e.kind     = KIND_OP;
					e.token_id = t.token_id;
					e.prec     = t.precedence;
					e.assoc    = t.assoc_left;
					err = push_entry(e);
				end
				KIND_RPAREN: begin
					while (held_cnt > 0 && held_ops[held_cnt-1].kind != KIND_LPAREN)
						pop_put();
					if (held_cnt > 0)
						held_cnt--;
					else
						err = ST_MISMATCH;
				end
				default: err = ST_UNDEF;
			endcase
			if (err != ST_TOKEN) begin
				put('0, '0, err);
				discarding = 1'b1;
				held_cnt   = 0;
			end
		end
		if (t.last_token) begin
			// flush; a left paren still on the stack is a mismatch
			if (!discarding) begin
				halt = 1'b0;
				while (held_cnt > 0 && !halt) begin
					if (held_ops[held_cnt-1].kind == KIND_LPAREN) begin
						put('0, '0, ST_MISMATCH);
						discarding = 1'b1;
						halt = 1'b1;
					end else
						pop_put();
				end
			end
			put('0, '0, discarding ? ST_END_ERR : ST_END_OK);
			discarding = 1'b0;
			held_cnt   = 0;
		end
		if (step_q.size() > 0)
			step_q[step_q.size()-1].last_of_run = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// scoreboard: results are checked before the token of the same edge
	// is predicted, a result can never belong to a token taken that edge
	// ------------------------------------------------------------------
	int      mismatches = 0;
	int      items_sent = 0;
	bit      row_typed  = 1'b0;  // current token carries a hand-written expectation
	result_t row_want   = '0;

	task automatic flag_error(string msg);
		if (mismatches < ERR_SHOWN)
			$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : score_p
		result_t w;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (postfix_q.size() == 0)
					flag_error($sformatf("unexpected result kind=%0d id=%h status=%0d last=%0d",
						res.out_kind, res.out_token_id, res.status, res.last_of_run));
				else begin
					w = postfix_q.pop_front();
					if (res.out_kind !== w.out_kind || res.out_token_id !== w.out_token_id ||
							res.status !== w.status || res.last_of_run !== w.last_of_run)
						flag_error($sformatf({"result mismatch: expected kind=%0d id=%h ",
							"status=%0d last=%0d, got kind=%0d id=%h status=%0d last=%0d"},
							w.out_kind, w.out_token_id, w.status, w.last_of_run,
							res.out_kind, res.out_token_id, res.status, res.last_of_run));
				end
			end
			if (tok_valid && !tok_stall) begin
				shunt_token(tok);
				if (row_typed)
					postfix_q = {postfix_q, row_want};
				else
					foreach (step_q[i])
						postfix_q = {postfix_q, step_q[i]};
			end
		end
	end

	// watchdog: a run of cycles with no transfer at all means a hang
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (tok_valid && !tok_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** infix_to_postfix_converter: FAILED **");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// receiver: stalls follow one of four random styles, drawn anew on a tick counter
	int stall_style = 0;
	int stall_tick  = 0;
	always @(negedge clk) begin
		if (stall_tick % 200 == 0)
			stall_style = $urandom_range(0, 3);
		stall_tick++;
		case (stall_style)
			0:       res_stall <= 1'b0;
			1:       res_stall <= ($urandom_range(0, 3) == 0);
			2:       res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= (stall_tick % 7 < 3);
		endcase
	end

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------
	bit calm       = 1'b0;  // no gaps between transfers
	int burst_left = 0;

	function automatic token_t any_token();
		token_t t;
		t.kind       = 3'($urandom_range(0, 7));
		t.token_id   = TOKEN_ID_BITS'($urandom);
		t.precedence = 4'($urandom_range(0, 15));
		t.assoc_left = 1'($urandom_range(0, 1));
		t.last_token = ($urandom_range(0, 3) == 0);
		return t;
	endfunction

	// drive one token, hold it until the transfer, then maybe leave a gap
	task automatic send_token(token_t t, bit typed, result_t want);
		int gap;
		@(negedge clk);
		tok       <= t;
		tok_valid <= 1'b1;
		row_typed = typed;
		row_want  = want;
		do @(posedge clk); while (tok_stall);
		if (!calm) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				@(negedge clk);
				tok_valid <= 1'b0;
				tok       <= any_token();
				repeat (gap - 1) @(negedge clk);
				burst_left = $urandom_range(1, 12);
			end else
				burst_left--;
		end
	endtask

	// hold off until every expected result has come back
	task automatic wait_drained();
		@(negedge clk);
		tok_valid <= 1'b0;
		while (postfix_q.size() != 0)
			@(negedge clk);
	endtask

	// well-formed infix expression with random ids, precedences and nesting
	token_t expr_q [$];

	function automatic void build_expr(int max_depth);
		int     depth;
		int     terms;
		int     goal;
		int     r;
		bit     want_operand;
		token_t t;
		expr_q.delete();
		depth        = 0;
		terms        = 0;
		goal         = $urandom_range(1, 8);
		want_operand = 1'b1;
		while (want_operand || terms < goal || depth > 0) begin
			t = any_token();
			t.last_token = 1'b0;
			r = $urandom_range(0, 9);
			if (want_operand) begin
				if (r < 5 || depth >= max_depth || terms >= goal) begin
					t.kind = KIND_CONST;
					want_operand = 1'b0;
					terms++;
				end else if (r < 7) begin
					// function call: name then opening paren
					t.kind = KIND_FUNC;
					expr_q = {expr_q, t};
					t = any_token();
					t.last_token = 1'b0;
					t.kind = KIND_LPAREN;
					depth++;
				end else if (r < 8)
					t.kind = KIND_FUNC;  // bare prefix function
				else begin
					t.kind = KIND_LPAREN;
					depth++;
				end
			end else if (depth > 0 && (r < 3 || terms >= goal)) begin
				t.kind = KIND_RPAREN;
				depth--;
			end else if (depth > 0 && r < 5) begin
				t.kind = KIND_SEP;
				want_operand = 1'b1;
			end else begin
				// mostly a narrow band so ties and associativity matter
				t.kind = KIND_OP;
				t.precedence = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(4, 6));
				want_operand = 1'b1;
			end
			expr_q = {expr_q, t};
		end
		expr_q[expr_q.size()-1].last_token = 1'b1;
	endfunction

	// directed table
	typedef struct {
		token_t  tok;
		bit      typed;
		result_t want;
	} row_t;

	row_t dir_rows [$];

	function automatic token_t tk(logic [2:0] k, logic [TOKEN_ID_BITS-1:0] id,
			logic [3:0] p, logic la, logic last);
		token_t t;
		t.kind       = k;
		t.token_id   = id;
		t.precedence = p;
		t.assoc_left = la;
		t.last_token = last;
		return t;
	endfunction

	// single-result rows only, so the one result closes the run
	function automatic result_t rs(logic [2:0] k, logic [TOKEN_ID_BITS-1:0] id, status_t s);
		result_t r;
		r.out_kind     = k;
		r.out_token_id = id;
		r.status       = s;
		r.last_of_run  = 1'b1;
		return r;
	endfunction

	function automatic void add_row(token_t t, bit typed, result_t want);
		row_t row;
		row.tok   = t;
		row.typed = typed;
		row.want  = want;
		dir_rows = {dir_rows, row};
	endfunction

	initial begin
		int kind_pick;
		int pick;
		int idx;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes of the fields straight after reset
		add_row(tk(KIND_CONST, 16'hFFFF, 4'd15, 1'b1, 1'b0), 1'b1,
			rs(KIND_CONST, 16'hFFFF, ST_TOKEN));
		add_row(tk(KIND_CONST, 16'h0000, 4'd0, 1'b0, 1'b1), 1'b0, '0);
		// undefined kind, then discard mode until the last token
		add_row(tk(KIND_UNDEF_HI, 16'hABCD, 4'd15, 1'b1, 1'b0), 1'b1,
			rs('0, '0, ST_UNDEF));
		add_row(tk(KIND_OP, 16'h0055, 4'd7, 1'b1, 1'b1), 1'b1, rs('0, '0, ST_END_ERR));
		// closing paren and separator on an empty stack
		add_row(tk(KIND_RPAREN, 16'h0001, 4'd0, 1'b0, 1'b0), 1'b1,
			rs('0, '0, ST_MISMATCH));
		add_row(tk(KIND_CONST, 16'h0002, 4'd0, 1'b0, 1'b1), 1'b1, rs('0, '0, ST_END_ERR));
		add_row(tk(KIND_SEP, 16'h0003, 4'd9, 1'b1, 1'b1), 1'b0, '0);
		// f(a, b) + c ^ d ^ e * g: function popped by an operator,
		// right association holds, left association pops equal precedence
		add_row(tk(KIND_FUNC, 16'h0010, 4'd5, 1'b1, 1'b0), 1'b0, '0);
		add_row(tk(KIND_LPAREN, 16'h0011, 4'd5, 1'b0, 1'b0), 1'b0, '0);
		add_row(tk(KIND_CONST, 16'h0012, 4'd0, 1'b0, 1'b0), 1'b0, '0);
		add_row(tk(KIND_SEP, 16'h0013, 4'd0, 1'b0, 1'b0), 1'b0, '0);
		add_row(tk(KIND_CONST, 16'h0014, 4'd0, 1'b0, 1'b0), 1'b0, '0);
		add_row(tk(KIND_RPAREN, 16'h0015, 4'd0, 1'b0, 1'b0), 1'b0, '0);
		add_row(tk(KIND_OP, 16'h0016, 4'd0, 1'b1, 1'b0), 1'b0, '0);
		add_row(tk(KIND_CONST, 16'h0017, 4'd0, 1'b0, 1'b0), 1'b0, '0);
		add_row(tk(KIND_OP, 16'h0018, 4'd15, 1'b0, 1'b0), 1'b0, '0);
		add_row(tk(KIND_CONST, 16'h0019, 4'd0, 1'b0, 1'b0), 1'b0, '0);
		add_row(tk(KIND_OP, 16'h001A, 4'd15, 1'b0, 1'b0), 1'b0, '0);
		add_row(tk(KIND_CONST, 16'h001B, 4'd0, 1'b0, 1'b0), 1'b0, '0);
		add_row(tk(KIND_OP, 16'h001C, 4'd15, 1'b1, 1'b0), 1'b0, '0);
		add_row(tk(KIND_CONST, 16'h001D, 4'd0, 1'b0, 1'b1), 1'b0, '0);
		// flush runs into an open paren
		add_row(tk(KIND_LPAREN, 16'h0020, 4'd3, 1'b1, 1'b1), 1'b0, '0);
		// error on the last token
		add_row(tk(KIND_UNDEF_LO, 16'h0021, 4'd3, 1'b0, 1'b1), 1'b0, '0);
		// operator right after a bare function, flushed at once
		add_row(tk(KIND_FUNC, 16'h0030, 4'd0, 1'b0, 1'b0), 1'b0, '0);
		add_row(tk(KIND_OP, 16'h0031, 4'd3, 1'b0, 1'b1), 1'b0, '0);

		foreach (dir_rows[i]) begin
			send_token(dir_rows[i].tok, dir_rows[i].typed, dir_rows[i].want);
			items_sent++;
		end
		wait_drained();

		// random expressions: mostly well-formed, some broken, some noise
		while (items_sent < ITEM_COUNT) begin
			calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 14)
				build_expr(($urandom_range(0, 7) == 0) ? 31 : 4);
			else if (pick < 17) begin
				build_expr(4);
				kind_pick = $urandom_range(0, 2);
				idx = $urandom_range(0, expr_q.size() - 1);
				if (kind_pick == 0)
					expr_q[idx].kind = 3'($urandom_range(0, 7));
				else if (kind_pick == 1 && expr_q.size() > 1)
					expr_q.delete($urandom_range(0, expr_q.size() - 2));
				else
					expr_q[expr_q.size()-1].last_token = 1'b0;  // runs into the next one
			end else if (pick < 18) begin
				// nest one level past the stack depth
				expr_q.delete();
				repeat (STACK_DEPTH + 1) begin
					expr_q = {expr_q, any_token()};
					expr_q[expr_q.size()-1].kind =
						($urandom_range(0, 1) != 0) ? KIND_LPAREN : KIND_FUNC;
					expr_q[expr_q.size()-1].last_token = 1'b0;
				end
				expr_q = {expr_q, tk(KIND_CONST, 16'h5A5A, 4'd0, 1'b0, 1'b1)};
			end else begin
				expr_q.delete();
				repeat ($urandom_range(1, 10))
					expr_q = {expr_q, any_token()};
			end
			// stop at the item budget, even inside an expression
			foreach (expr_q[i]) begin
				if (items_sent < ITEM_COUNT) begin
					send_token(expr_q[i], 1'b0, '0);
					items_sent++;
				end
			end
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && postfix_q.size() == 0)
			$display("** infix_to_postfix_converter: PASSED **");
		else
			$display("** infix_to_postfix_converter: FAILED **");
		$finish;
	end

endmodule

[infix_to_postfix_converter.f]
rtl/itp_pkg.sv
rtl/itp_ram.sv
rtl/itp_cmp.sv
rtl/infix_to_postfix_converter.sv
sim/tb.sv
